// ----- hdl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// shared types for the sorted key table: operation and status codes,
// sequencer states and the status bundle from the sequencer
// ----------------------------------------------------------------------------
package skt_pkg;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT,
    S_WR_NEW,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic    idle;
    logic    done;
    logic    found;
    status_t status;
  } seq_stat_t;

endpackage

// ----- hdl/skt_ram.sv -----
// ----------------------------------------------------------------------------
// skt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/skt_seq.sv -----
// ----------------------------------------------------------------------------
// skt_seq
// sequencer for the sorted key table: binary search probes, one-entry-a-cycle
// shifting for insert and remove, entry count and result registers
// ----------------------------------------------------------------------------
module skt_seq
  import skt_pkg::*;
#(
  parameter int CAPACITY  = 32,
  parameter int KEY_WIDTH = 8,
  parameter int REF_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [1:0]                      mode,
  input  logic [KEY_WIDTH-1:0]            key,
  input  logic [$clog2(CAPACITY+1)-1:0]   position,
  input  logic [REF_WIDTH-1:0]            child_ref,
  input  logic                            out_free,
  output seq_stat_t                       stat,
  output logic [$clog2(CAPACITY+1)-1:0]   res_idx,
  output logic [REF_WIDTH-1:0]            res_ref,
  output logic [$clog2(CAPACITY+1)-1:0]   count,
  output logic                            ram_we,
  output logic [$clog2(CAPACITY)-1:0]     ram_waddr,
  output logic [KEY_WIDTH+REF_WIDTH-1:0]  ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]     ram_raddr,
  input  logic [KEY_WIDTH+REF_WIDTH-1:0]  ram_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  seq_state_t           state, state_next;
  mode_t                mode_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [REF_WIDTH-1:0] ref_r;
  logic [CW-1:0]        pos_r;
  logic [CW-1:0]        lo, hi;
  logic [AW-1:0]        rd_ptr, wr_ptr;
  logic [CW-1:0]        left;
  logic                 pend;
  logic                 res_found;
  status_t              res_status;

  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        mid_inc;
  logic [KEY_WIDTH-1:0] rkey;
  logic [REF_WIDTH-1:0] rref;
  logic                 probe_gt, probe_lt;
  logic                 ins_full, ins_bad, rem_empty, rem_bad;
  logic                 rd_go;
  logic                 is_ins;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CW:1];
  assign mid_inc  = mid + 1'b1;
  assign rkey     = ram_rdata[KEY_WIDTH+REF_WIDTH-1:REF_WIDTH];
  assign rref     = ram_rdata[REF_WIDTH-1:0];
  assign probe_gt = (rkey > key_r);
  assign probe_lt = (rkey < key_r);

  assign ins_full  = (count >= CAP);
  assign ins_bad   = (position > count);
  assign rem_empty = (count == '0);
  assign rem_bad   = (position >= count);

  assign rd_go  = (left != '0);
  assign is_ins = (mode_r == MODE_INSERT);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (mode_t'(mode))
            MODE_SEARCH: state_next = rem_empty ? S_DONE : S_SRCH_RD;
            MODE_INSERT: begin
              if (ins_full || ins_bad) begin
                state_next = S_DONE;
              end else if (position == count) begin
                state_next = S_WR_NEW;
              end else begin
                state_next = S_SHIFT;
              end
            end
            MODE_REMOVE: begin
              if (rem_empty || rem_bad || (position + 1'b1 == count)) begin
                state_next = S_DONE;
              end else begin
                state_next = S_SHIFT;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SRCH_RD: state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (probe_gt) begin
          if (lo >= mid) state_next = S_DONE;
          else           state_next = S_SRCH_RD;
        end else if (probe_lt) begin
          if (mid_inc >= hi) state_next = S_DONE;
          else               state_next = S_SRCH_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!rd_go) state_next = is_ins ? S_WR_NEW : S_DONE;
      end
      S_WR_NEW: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = wr_ptr;
    ram_wdata   = ram_rdata;
    ram_raddr   = rd_ptr;
    stat.idle   = 1'b0;
    stat.done   = 1'b0;
    stat.found  = res_found;
    stat.status = res_status;
    case (state)
      S_IDLE:    stat.idle = 1'b1;
      S_SRCH_RD: ram_raddr = mid[AW-1:0];
      S_SHIFT:   ram_we = pend;
      S_WR_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = {key_r, ref_r};
      end
      S_DONE:    stat.done = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            mode_r    <= mode_t'(mode);
            key_r     <= key;
            ref_r     <= child_ref;
            pos_r     <= position;
            res_found <= 1'b0;
            res_ref   <= '0;
            lo        <= '0;
            hi        <= count;
            pend      <= 1'b0;
            case (mode_t'(mode))
              MODE_SEARCH: begin
                res_idx    <= '0;
                res_status <= ST_OK;
                left       <= '0;
              end
              MODE_INSERT: begin
                res_idx <= position;
                if (ins_full) begin
                  res_status <= ST_FULL;
                  left       <= '0;
                end else if (ins_bad) begin
                  res_status <= ST_BAD_POS;
                  left       <= '0;
                end else begin
                  res_status <= ST_OK;
                  rd_ptr     <= AW'(count - 1'b1);
                  left       <= count - position;
                end
              end
              MODE_REMOVE: begin
                res_idx <= position;
                if (rem_empty) begin
                  res_status <= ST_EMPTY;
                  left       <= '0;
                end else if (rem_bad) begin
                  res_status <= ST_BAD_POS;
                  left       <= '0;
                end else begin
                  res_status <= ST_OK;
                  count      <= count - 1'b1;
                  rd_ptr     <= AW'(position + 1'b1);
                  left       <= count - 1'b1 - position;
                end
              end
              default: begin
                count      <= '0;
                res_idx    <= '0;
                res_status <= ST_OK;
                left       <= '0;
              end
            endcase
          end
        end
        S_SRCH_CMP: begin
          if (probe_gt) begin
            hi      <= mid;
            res_idx <= lo;
          end else if (probe_lt) begin
            lo      <= mid_inc;
            res_idx <= mid_inc;
          end else begin
            res_found <= 1'b1;
            res_idx   <= mid;
            res_ref   <= rref;
          end
        end
        S_SHIFT: begin
          pend <= rd_go;
          if (rd_go) begin
            rd_ptr <= is_ins ? rd_ptr - 1'b1 : rd_ptr + 1'b1;
            wr_ptr <= is_ins ? rd_ptr + 1'b1 : rd_ptr - 1'b1;
            left   <= left - 1'b1;
          end
        end
        S_WR_NEW: count <= count + 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/sorted_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table
// ascending key table with a reference beside each key: search, insert at a
// position, remove at a position and clear, one result word per input word
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid / in_stall  mode, key, position, child_ref
//  out      out_valid/ out_stall found, index, ref_out, entry_count, status
//
//  one word at a time, through the single ram port pair (one read, one write
//  a cycle); search reads then compares each probe; insert moves each entry
//  from position upward one place, then writes the new entry (only the
//  write at the end of the table); remove moves each entry above position
//  down one place (none for the last entry); clear and rejected ops go to done
//  reset (synchronous) empties the table at once; no clearing pass is run
//  a finished result waits in the output register while the next input word
//  is taken; if it is still stalled when the next result is ready, the
//  sequencer holds that result and takes no further input
//
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int CAPACITY  = 32,
  parameter int KEY_WIDTH = 8,
  parameter int REF_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [KEY_WIDTH-1:0]          key,
  input  logic [$clog2(CAPACITY+1)-1:0] position,
  input  logic [REF_WIDTH-1:0]          child_ref,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [$clog2(CAPACITY+1)-1:0] index,
  output logic [REF_WIDTH-1:0]          ref_out,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count,
  output logic [1:0]                    status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int DW = KEY_WIDTH + REF_WIDTH;

  seq_stat_t      stat;
  logic [CW-1:0]  res_idx;
  logic [REF_WIDTH-1:0] res_ref;
  logic [CW-1:0]  count;
  logic           out_free;
  logic           start;
  logic           load;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [DW-1:0]  ram_wdata, ram_rdata;

  // input taken only while the sequencer sits idle
  assign in_stall = !stat.idle;
  assign start    = in_valid && stat.idle;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  assign load     = stat.done && out_free;

  skt_seq #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH),
    .REF_WIDTH(REF_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mode     (mode),
    .key      (key),
    .position (position),
    .child_ref(child_ref),
    .out_free (out_free),
    .stat     (stat),
    .res_idx  (res_idx),
    .res_ref  (res_ref),
    .count    (count),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  // key and reference kept side by side in one word per entry
  skt_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found       <= stat.found;
      index       <= res_idx;
      ref_out     <= res_ref;
      entry_count <= count;
      status      <= stat.status;
    end
  end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb - self-checking bench for sorted_key_table
// drives search, insert, remove and clear words through the valid/stall
// handshake, predicts every result word from a private copy of the table and
// compares each accepted result field by field, in order
// ----------------------------------------------------------------------------

import skt_pkg::*;

localparam int CAP   = 32;
localparam int KEY_W = 8;
localparam int REF_W = 16;
localparam int IDX_W = $clog2(CAP + 1);

typedef struct {
  logic             found;
  logic [IDX_W-1:0] index;
  logic [REF_W-1:0] ref_out;
  logic [IDX_W-1:0] entry_count;
  status_t          status;
} table_reply_t;

// private copy of the table plus the queue of result words still owed
class key_table_check;
  logic [KEY_W-1:0] key_copy [CAP];
  logic [REF_W-1:0] link_copy [CAP];
  int               held;
  table_reply_t     replies_due [$];
  int               bad_words;

  function new();
    held      = 0;
    bad_words = 0;
    foreach (key_copy[i]) begin
      key_copy[i]  = '0;
      link_copy[i] = '0;
    end
  endfunction

  function int entries();
    return held;
  endfunction

  function int pending();
    return replies_due.size();
  endfunction

  function logic [KEY_W-1:0] key_at(int i);
    return key_copy[i];
  endfunction

  // binary search over the held entries: match index, or insertion point
  function void probe(input logic [KEY_W-1:0] k, output bit hit, output int at);
    int lo;
    int hi;
    int mid;
    lo  = 0;
    hi  = held;
    hit = 1'b0;
    at  = 0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (key_copy[mid] > k) begin
        hi = mid;
      end else if (key_copy[mid] < k) begin
        lo = mid + 1;
      end else begin
        hit = 1'b1;
        at  = mid;
      end
    end
    if (!hit) at = lo;
  endfunction

  function void note_word(mode_t op, logic [KEY_W-1:0] k, logic [IDX_W-1:0] p,
                          logic [REF_W-1:0] cr);
    table_reply_t rep;
    bit           hit;
    int           at;
    rep.found   = 1'b0;
    rep.index   = p;
    rep.ref_out = '0;
    rep.status  = ST_OK;
    case (op)
      MODE_SEARCH: begin
        probe(k, hit, at);
        rep.found = hit;
        rep.index = IDX_W'(at);
        if (hit) rep.ref_out = link_copy[at];
      end
      MODE_INSERT: begin
        if (held >= CAP) begin
          rep.status = ST_FULL;
        end else if (int'(p) > held) begin
          rep.status = ST_BAD_POS;
        end else begin
          for (int i = held; i > int'(p); i--) begin
            key_copy[i]  = key_copy[i-1];
            link_copy[i] = link_copy[i-1];
          end
          key_copy[int'(p)]  = k;
          link_copy[int'(p)] = cr;
          held++;
        end
      end
      MODE_REMOVE: begin
        if (held == 0) begin
          rep.status = ST_EMPTY;
        end else if (int'(p) >= held) begin
          rep.status = ST_BAD_POS;
        end else begin
          held--;
          for (int i = int'(p); i < held; i++) begin
            key_copy[i]  = key_copy[i+1];
            link_copy[i] = link_copy[i+1];
          end
        end
      end
      default: begin
        held      = 0;
        rep.index = '0;
      end
    endcase
    rep.entry_count = IDX_W'(held);
    replies_due.push_back(rep);
  endfunction

  function void flag(string what, table_reply_t want, table_reply_t got);
    bad_words++;
    if (bad_words <= 10)
      $display("tb: %s: want %0d/%0d/%h/%0d/%0d got %0d/%0d/%h/%0d/%0d",
               what, want.found, want.index, want.ref_out, want.entry_count,
               want.status, got.found, got.index, got.ref_out, got.entry_count,
               got.status);
  endfunction

  function void check_word(table_reply_t got);
    table_reply_t want;
    if (replies_due.size() == 0) begin
      want.found       = 1'b0;
      want.index       = '0;
      want.ref_out     = '0;
      want.entry_count = '0;
      want.status      = ST_OK;
      flag("result with nothing owed", want, got);
    end else begin
      want = replies_due.pop_front();
      if (want.found !== got.found || want.index !== got.index ||
          want.ref_out !== got.ref_out || want.entry_count !== got.entry_count ||
          want.status !== got.status)
        flag("mismatch (found/index/ref/count/status)", want, got);
    end
  endfunction
endclass

module tb;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel, driven to known values from time zero
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [1:0]       mode      = MODE_SEARCH;
  logic [KEY_W-1:0] key       = '0;
  logic [IDX_W-1:0] position  = '0;
  logic [REF_W-1:0] child_ref = '0;

  // result channel
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             found;
  logic [IDX_W-1:0] index;
  logic [REF_W-1:0] ref_out;
  logic [IDX_W-1:0] entry_count;
  logic [1:0]       status;

  key_table_check table_check;
  int             words_sent = 0;

  sorted_key_table #(
    .CAPACITY (CAP),
    .KEY_WIDTH(KEY_W),
    .REF_WIDTH(REF_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .key        (key),
    .position   (position),
    .child_ref  (child_ref),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .index      (index),
    .ref_out    (ref_out),
    .entry_count(entry_count),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one word and hold it until the block takes it; random idle gaps
  // before the word, except for a calm stretch of words in the middle
  task automatic send_word(input mode_t op, input logic [KEY_W-1:0] k,
                           input logic [IDX_W-1:0] p, input logic [REF_W-1:0] cr);
    if (!(words_sent >= 700 && words_sent < 900)) begin
      while ($urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    mode      <= op;
    key       <= k;
    position  <= p;
    child_ref <= cr;
    @(posedge clk);
    // stall as seen at this edge, before the block updates it
    while (in_stall) @(posedge clk);
    table_check.note_word(op, k, p, cr);
    words_sent++;
  endtask

  // result side: random stalls, a calm window, and one long hold-off that
  // lets the block back up and stall its input while words keep coming
  initial begin : result_sink
    int  sink_cycles;
    int  hold_left;
    bit  held_off;
    sink_cycles = 0;
    hold_left   = 0;
    held_off    = 1'b0;
    forever begin
      @(posedge clk);
      sink_cycles++;
      if (!held_off && words_sent >= 300) begin
        held_off  = 1'b1;
        hold_left = 240;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (sink_cycles >= 6000 && sink_cycles < 12000) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 14);
      end
    end
  end

  // every accepted result word goes to the checker, oldest prediction first
  always @(posedge clk) begin
    table_reply_t got;
    if (!rst && out_valid && !out_stall) begin
      got.found       = found;
      got.index       = index;
      got.ref_out     = ref_out;
      got.entry_count = entry_count;
      got.status      = status_t'(status);
      table_check.check_word(got);
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] k;
    logic [IDX_W-1:0] p;
    logic [REF_W-1:0] cr;
    int               held;
    int               pick;
    int               at;
    bit               hit;
    bit               grow;

    table_check = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table corner cases
    send_word(MODE_SEARCH, 8'h00, 6'd0, 16'h0000);
    send_word(MODE_REMOVE, 8'h00, 6'd0, 16'h0000);
    send_word(MODE_INSERT, 8'h10, 6'd1, 16'h1234);
    // build 00 55 80 ff with extreme references
    send_word(MODE_INSERT, 8'h80, 6'd0, 16'hFFFF);
    send_word(MODE_INSERT, 8'h00, 6'd0, 16'h0000);
    send_word(MODE_INSERT, 8'hFF, 6'd2, 16'hA5A5);
    send_word(MODE_INSERT, 8'h55, 6'd1, 16'h5A5A);
    // hits at both ends and inside, misses between keys
    send_word(MODE_SEARCH, 8'hFF, 6'd32, 16'hFFFF);
    send_word(MODE_SEARCH, 8'h00, 6'd0, 16'h0000);
    send_word(MODE_SEARCH, 8'h80, 6'd5, 16'h0F0F);
    send_word(MODE_SEARCH, 8'h7F, 6'd0, 16'h0000);
    send_word(MODE_SEARCH, 8'hAA, 6'd0, 16'h0000);
    // positions at and past the end
    send_word(MODE_REMOVE, 8'h00, 6'd4, 16'h0000);
    send_word(MODE_REMOVE, 8'h00, 6'd32, 16'h0000);
    send_word(MODE_INSERT, 8'hFF, 6'd32, 16'hFFFF);
    // remove first and last
    send_word(MODE_REMOVE, 8'h00, 6'd0, 16'h0000);
    send_word(MODE_REMOVE, 8'hFF, 6'd2, 16'hFFFF);
    send_word(MODE_SEARCH, 8'hFF, 6'd0, 16'h0000);
    // clear with junk in every field, then search the empty table
    send_word(MODE_CLEAR, 8'hFF, 6'd32, 16'hFFFF);
    send_word(MODE_SEARCH, 8'h55, 6'd0, 16'h0000);

    // random: mostly sorted inserts, searches for held and absent keys and
    // valid removes; the table swings between empty and full so that the
    // full and empty cases keep coming up
    grow = 1'b1;
    repeat (1200) begin
      held = table_check.entries();
      if (held == CAP && $urandom_range(3) == 0) grow = 1'b0;
      if (held == 0) grow = 1'b1;
      pick = $urandom_range(99);
      k    = KEY_W'($urandom_range(255));
      p    = IDX_W'($urandom_range(CAP));
      cr   = REF_W'($urandom_range(16'hFFFF));
      if (pick < 38) begin
        if (held != 0 && $urandom_range(1) == 1) k = table_check.key_at($urandom_range(held - 1));
        send_word(MODE_SEARCH, k, p, cr);
      end else if (pick < (grow ? 80 : 58)) begin
        // the odd insert lands at a random position, out of order or past the end
        if ($urandom_range(19) != 0) begin
          table_check.probe(k, hit, at);
          p = IDX_W'(at);
        end
        send_word(MODE_INSERT, k, p, cr);
      end else if (pick < 98) begin
        if (held != 0 && $urandom_range(6) != 0) p = IDX_W'($urandom_range(held - 1));
        else p = IDX_W'($urandom_range(CAP, held));
        send_word(MODE_REMOVE, k, p, cr);
      end else begin
        send_word(MODE_CLEAR, k, p, cr);
      end
    end
    in_valid <= 1'b0;

    // drain, then allow for the longest operation before the verdict
    while (table_check.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (table_check.bad_words == 0 && table_check.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("tb: errors");
    $finish;
  end

endmodule
